// ===== design/ggc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared types and constants for the greedy first-fit graph coloring block:
// graph size limits, field widths, command and status codes, beat structs.
// ----------------------------------------------------------------------------
package ggc_pkg;

    // Graph size limits
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;
    localparam int MAX_COLORS   = 64;

    // Field widths of the beats
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 14;
    localparam int VAL_W   = 14;
    localparam int COLOR_W = 11;
    localparam int ST_W    = 2;

    // Storage geometry
    localparam int ROW_DEPTH = MAX_VERTICES + 1;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);
    localparam int OFF_W     = 14;
    localparam int VID_W     = $clog2(MAX_VERTICES);
    localparam int EID_W     = $clog2(MAX_EDGES);
    localparam int TAKEN_AW  = $clog2(MAX_COLORS);
    localparam int VCNT_W    = 11;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WR_ROW   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_NB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_COLOR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_COLOR = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [ST_W-1:0]    status;
    } t_out_beat;

endpackage : ggc_pkg
`default_nettype wire

// ===== design/greedy_first_fit_graph_coloring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_first_fit_graph_coloring
// CSR graph store with a sequencer that gives every vertex 0..vertex_count-1
// the smallest color 1..64 not held by any of its neighbors.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (command,index,value)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (read_color,status)
//  cfg     | input     | i_cfg_wr_en, no wait       | i_cfg_wr_data (vertex_count)
//
//  Sequence: load commands and rejected beats answer straight from IDLE; a
//  color read passes S_READ (one registered read of the color memory). A run
//  visits per vertex S_ROW_LO and S_ROW_HI (two row offset reads), S_ROW_END,
//  then per edge S_NB, S_COL and S_MARK (a neighbor id read followed by a
//  dependent color read, one read port per memory), then S_PICK to pick and write the color.
//  Reset clears the sequencer, the output valid flag, the taken set and
//  vertex_count only; the three memories hold garbage until loaded. A stalled
//  output holds its beat and keeps o_in_ready low, except that a new beat is
//  taken in the cycle the waiting one drains.
// ----------------------------------------------------------------------------
module greedy_first_fit_graph_coloring (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  ggc_pkg::t_in_beat                   i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output ggc_pkg::t_out_beat                  o_out_data,
    input  wire                                 i_cfg_wr_en,
    input  wire  [ggc_pkg::VCNT_W-1:0]          i_cfg_wr_data
);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_READ    = 4'd1;
    localparam logic [3:0] S_ROW_LO  = 4'd2;
    localparam logic [3:0] S_ROW_HI  = 4'd3;
    localparam logic [3:0] S_ROW_END = 4'd4;
    localparam logic [3:0] S_NB      = 4'd5;
    localparam logic [3:0] S_COL     = 4'd6;
    localparam logic [3:0] S_MARK    = 4'd7;
    localparam logic [3:0] S_PICK    = 4'd8;

    // Memories: row offsets, neighbor ids, vertex colors
    logic [ggc_pkg::OFF_W-1:0]   r_row_mem [0:ggc_pkg::ROW_DEPTH-1];
    logic [ggc_pkg::VID_W-1:0]   r_nb_mem  [0:ggc_pkg::MAX_EDGES-1];
    logic [ggc_pkg::COLOR_W-1:0] r_col_mem [0:ggc_pkg::MAX_VERTICES-1];

    // Registered read data
    logic [ggc_pkg::OFF_W-1:0]   r_row_rd;
    logic [ggc_pkg::VID_W-1:0]   r_nb_rd;
    logic [ggc_pkg::COLOR_W-1:0] r_col_rd;

    // Memory port controls
    logic                        row_we;
    logic [ggc_pkg::ROW_AW-1:0]  row_waddr;
    logic [ggc_pkg::OFF_W-1:0]   row_wdata;
    logic [ggc_pkg::ROW_AW-1:0]  row_raddr;
    logic                        nb_we;
    logic [ggc_pkg::EID_W-1:0]   nb_waddr;
    logic [ggc_pkg::VID_W-1:0]   nb_wdata;
    logic [ggc_pkg::EID_W-1:0]   nb_raddr;
    logic                        col_we;
    logic [ggc_pkg::VID_W-1:0]   col_waddr;
    logic [ggc_pkg::COLOR_W-1:0] col_wdata;
    logic [ggc_pkg::VID_W-1:0]   col_raddr;

    // Control and working registers
    logic [3:0]                   r_state, n_state;
    logic [ggc_pkg::VCNT_W-1:0]   r_vcount;
    logic [ggc_pkg::VCNT_W-1:0]   r_v, n_v;
    logic [ggc_pkg::OFF_W-1:0]    r_e, n_e;
    logic [ggc_pkg::OFF_W-1:0]    r_end, n_end;
    logic [ggc_pkg::MAX_COLORS-1:0] r_taken, n_taken;
    logic                         r_ovf, n_ovf;
    logic                         r_out_valid, n_out_valid;
    ggc_pkg::t_out_beat           r_out, n_out;

    logic                         in_acc;
    logic [ggc_pkg::OFF_W-1:0]    e_inc;
    logic [ggc_pkg::VCNT_W-1:0]   v_inc;
    logic                         free_found;
    logic [ggc_pkg::COLOR_W-1:0]  free_color;
    logic [ggc_pkg::TAKEN_AW-1:0] mark_bit;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign e_inc    = r_e + ggc_pkg::OFF_W'(1);
    assign v_inc    = r_v + ggc_pkg::VCNT_W'(1);
    assign mark_bit = ggc_pkg::TAKEN_AW'(r_col_rd - ggc_pkg::COLOR_W'(1));

    // First free color: scan down so the lowest clear bit wins
    always_comb begin
        free_found = 1'b0;
        free_color = '0;
        for (int c = ggc_pkg::MAX_COLORS - 1; c >= 0; c--) begin
            if (!r_taken[c]) begin
                free_found = 1'b1;
                free_color = ggc_pkg::COLOR_W'(c + 1);
            end
        end
    end

    // Sequencer and port steering
    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_e         = r_e;
        n_end       = r_end;
        n_taken     = r_taken;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        row_we    = 1'b0;
        row_waddr = i_in_data.index[ggc_pkg::ROW_AW-1:0];
        row_wdata = i_in_data.value[ggc_pkg::OFF_W-1:0];
        row_raddr = r_v;
        nb_we     = 1'b0;
        nb_waddr  = i_in_data.index[ggc_pkg::EID_W-1:0];
        nb_wdata  = i_in_data.value[ggc_pkg::VID_W-1:0];
        nb_raddr  = r_e[ggc_pkg::EID_W-1:0];
        col_we    = 1'b0;
        col_waddr = i_in_data.index[ggc_pkg::VID_W-1:0];
        col_wdata = i_in_data.value[ggc_pkg::COLOR_W-1:0];
        col_raddr = i_in_data.index[ggc_pkg::VID_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // Default answer: ok, no color; load it unless deferred
                    n_out.read_color = '0;
                    n_out.status     = ggc_pkg::ST_OK;
                    n_out_valid      = 1'b1;
                    case (i_in_data.command)
                        ggc_pkg::CMD_WR_ROW: begin
                            if (i_in_data.index <= ggc_pkg::IDX_W'(ggc_pkg::MAX_VERTICES)
                                && i_in_data.value <= ggc_pkg::VAL_W'(ggc_pkg::MAX_EDGES)) begin
                                row_we = 1'b1;
                            end else begin
                                n_out.status = ggc_pkg::ST_RANGE;
                            end
                        end
                        ggc_pkg::CMD_WR_NB: begin
                            if (i_in_data.index < ggc_pkg::IDX_W'(ggc_pkg::MAX_EDGES)
                                && i_in_data.value < ggc_pkg::VAL_W'(ggc_pkg::MAX_VERTICES)) begin
                                nb_we = 1'b1;
                            end else begin
                                n_out.status = ggc_pkg::ST_RANGE;
                            end
                        end
                        ggc_pkg::CMD_WR_COLOR: begin
                            if (i_in_data.index < ggc_pkg::IDX_W'(ggc_pkg::MAX_VERTICES)
                                && i_in_data.value <= ggc_pkg::VAL_W'(ggc_pkg::MAX_VERTICES)) begin
                                col_we = 1'b1;
                            end else begin
                                n_out.status = ggc_pkg::ST_RANGE;
                            end
                        end
                        ggc_pkg::CMD_RUN: begin
                            if (r_vcount > ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES)) begin
                                n_out.status = ggc_pkg::ST_RANGE;
                            end else if (r_vcount != '0) begin
                                n_out_valid = 1'b0;
                                n_v         = '0;
                                n_ovf       = 1'b0;
                                n_state     = S_ROW_LO;
                            end
                        end
                        ggc_pkg::CMD_RD_COLOR: begin
                            if (i_in_data.index < ggc_pkg::IDX_W'(ggc_pkg::MAX_VERTICES)) begin
                                // Hold the answer until the color memory returns
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end else begin
                                n_out.status = ggc_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_out.status = ggc_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out.read_color = r_col_rd;
                n_out.status     = ggc_pkg::ST_OK;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end
            S_ROW_LO: begin
                // Fetch start offset, start a fresh taken set
                row_raddr = r_v;
                n_taken   = '0;
                n_state   = S_ROW_HI;
            end
            S_ROW_HI: begin
                row_raddr = v_inc;
                n_e       = r_row_rd;
                n_state   = S_ROW_END;
            end
            S_ROW_END: begin
                n_end = r_row_rd;
                if (r_e < r_row_rd && r_e < ggc_pkg::OFF_W'(ggc_pkg::MAX_EDGES)) begin
                    n_state = S_NB;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_NB: begin
                nb_raddr = r_e[ggc_pkg::EID_W-1:0];
                n_state  = S_COL;
            end
            S_COL: begin
                col_raddr = r_nb_rd;
                n_state   = S_MARK;
            end
            S_MARK: begin
                // Colors 0 and above the tracked range mark nothing
                if (r_col_rd != '0
                    && r_col_rd <= ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS)) begin
                    n_taken[mark_bit] = 1'b1;
                end
                n_e = e_inc;
                if (e_inc < r_end && e_inc < ggc_pkg::OFF_W'(ggc_pkg::MAX_EDGES)) begin
                    n_state = S_NB;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                col_waddr = r_v[ggc_pkg::VID_W-1:0];
                col_wdata = free_color;
                if (free_found) begin
                    col_we = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_v = v_inc;
                if (v_inc < r_vcount) begin
                    n_state = S_ROW_LO;
                end else begin
                    n_out.read_color = '0;
                    n_out.status     = (r_ovf || !free_found) ? ggc_pkg::ST_OVERFLOW
                                                              : ggc_pkg::ST_OK;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_waddr] <= row_wdata;
        end
        r_row_rd <= r_row_mem[row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[nb_waddr] <= nb_wdata;
        end
        r_nb_rd <= r_nb_mem[nb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[col_waddr] <= col_wdata;
        end
        r_col_rd <= r_col_mem[col_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vcount    <= '0;
            r_taken     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_taken     <= n_taken;
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_e   <= n_e;
        r_end <= n_end;
        r_ovf <= n_ovf;
        r_out <= n_out;
    end

    // While the sequencer is busy the output slot must be empty
    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("output register holds a beat while an item is in progress");

    // Edge walk stays inside the vertex's range and the edge table
    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB || r_state == S_COL || r_state == S_MARK)
        |-> (r_e < r_end && r_e < ggc_pkg::OFF_W'(ggc_pkg::MAX_EDGES)))
        else $error("edge pointer outside its neighbor range");

    // Vertex counter stays below the configured count during a run
    a_vertex_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW_LO || r_state == S_PICK) |-> (r_v < r_vcount))
        else $error("vertex counter ran past vertex_count");

endmodule : greedy_first_fit_graph_coloring
`default_nettype wire
